/* rtl/fegu_pkg.sv */
`timescale 1ns / 1ps
package fegu_pkg;

  localparam int GRID_ROWS   = 40;
  localparam int GRID_COLS   = 40;
  localparam int CELL_COUNT  = GRID_ROWS * GRID_COLS;
  localparam int CIDX_W      = $clog2(CELL_COUNT);
  localparam int ROW_W       = $clog2(GRID_ROWS);
  localparam int COL_W       = $clog2(GRID_COLS);
  localparam int BOTTOM_BASE = CELL_COUNT - GRID_COLS;
  localparam int LAST_CELL   = CELL_COUNT - 1;

  localparam int HEAT_W     = 6;
  localparam int RAND_W     = 32;
  localparam int COLOR_W    = 32;
  localparam int OUT_IDX_W  = 11;
  localparam int WIND_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [HEAT_W-1:0] HEAT_MAX = 6'd36;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_SPAN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIND_SHIFT  = 2'd2;

  localparam logic [HEAT_W-1:0] SOURCE_HEAT_RST = 6'd36;
  localparam logic [HEAT_W-1:0] DECAY_SPAN_RST  = 6'd3;
  localparam logic [WIND_W-1:0] WIND_SHIFT_RST  = 5'h1D;

  localparam logic [1:0] CMD_IGNITE    = 2'd0;
  localparam logic [1:0] CMD_PROPAGATE = 2'd1;
  localparam logic [1:0] CMD_READ      = 2'd2;

  typedef enum logic [1:0] {
    OP_IGNITE,
    OP_PROPAGATE,
    OP_READ
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [RAND_W-1:0]  rand_val;
    logic [CIDX_W-1:0]  rd_idx;
  } q_entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROP,
    ST_READ,
    ST_IGN_OUT
  } back_state_e;

  function automatic logic [COLOR_W-1:0] heat_color(input logic [HEAT_W-1:0] h);
    logic [COLOR_W-1:0] c;
    case (h)
      6'd0:  c = 32'hFF070707;
      6'd1:  c = 32'hFF1F0707;
      6'd2:  c = 32'hFF2F0F07;
      6'd3:  c = 32'hFF470F07;
      6'd4:  c = 32'hFF571707;
      6'd5:  c = 32'hFF671F07;
      6'd6:  c = 32'hFF771F07;
      6'd7:  c = 32'hFF8F2707;
      6'd8:  c = 32'hFF9F2F07;
      6'd9:  c = 32'hFFAF3F07;
      6'd10: c = 32'hFFBF4707;
      6'd11: c = 32'hFFC74707;
      6'd12: c = 32'hFFDF4707;
      6'd13: c = 32'hFFDF5707;
      6'd14: c = 32'hFFDF5707;
      6'd15: c = 32'hFFD75F07;
      6'd16: c = 32'hFFD75F07;
      6'd17: c = 32'hFFD7670F;
      6'd18: c = 32'hFFCF6F0F;
      6'd19: c = 32'hFFCF770F;
      6'd20: c = 32'hFFCF7F0F;
      6'd21: c = 32'hFFCF8717;
      6'd22: c = 32'hFFC78717;
      6'd23: c = 32'hFFC78F17;
      6'd24: c = 32'hFFC7971F;
      6'd25: c = 32'hFFBF9F1F;
      6'd26: c = 32'hFFBF9F1F;
      6'd27: c = 32'hFFBFA727;
      6'd28: c = 32'hFFBFA727;
      6'd29: c = 32'hFFBFAF2F;
      6'd30: c = 32'hFFB7AF2F;
      6'd31: c = 32'hFFB7B72F;
      6'd32: c = 32'hFFB7B737;
      6'd33: c = 32'hFFCFCF6F;
      6'd34: c = 32'hFFDFDF9F;
      6'd35: c = 32'hFFEFEFC7;
      default: c = 32'hFFFFFFFF;
    endcase
    return c;
  endfunction

endpackage

/* rtl/fegu_ram.sv */
`timescale 1ns / 1ps
module fegu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/fegu_front.sv */
`timescale 1ns / 1ps
module fegu_front
  import fegu_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        command_i,
  input  logic [RAND_W-1:0] random_value_i,
  input  logic [5:0]        read_row_i,
  input  logic [5:0]        read_col_i,
  input  logic              hold_i,
  output logic              q_valid_o,
  output q_entry_t          q_entry_o,
  input  logic              q_pop_i
);

  q_entry_t   entry_q [QUEUE_DEPTH];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  logic       full;
  logic       accept;
  logic       push;
  q_entry_t   new_entry;
  logic [ROW_W-1:0] row_sat;
  logic [COL_W-1:0] col_sat;

  assign full       = (count_q == 2'(QUEUE_DEPTH));
  assign in_stall_o = full || hold_i;
  assign accept     = in_valid_i && !in_stall_o;

  // saturate the read coordinates and form the linear address up front
  always_comb begin
    row_sat = (int'(read_row_i) > GRID_ROWS - 1) ? ROW_W'(GRID_ROWS - 1) : ROW_W'(read_row_i);
    col_sat = (int'(read_col_i) > GRID_COLS - 1) ? COL_W'(GRID_COLS - 1) : COL_W'(read_col_i);
    new_entry.rand_val = random_value_i;
    new_entry.rd_idx   = CIDX_W'(int'(row_sat) * GRID_COLS + int'(col_sat));
    new_entry.op       = OP_READ;
    push               = 1'b0;
    unique case (command_i)
      CMD_IGNITE: begin
        new_entry.op = OP_IGNITE;
        push         = accept;
      end
      CMD_PROPAGATE: begin
        new_entry.op = OP_PROPAGATE;
        push         = accept;
      end
      CMD_READ: begin
        new_entry.op = OP_READ;
        push         = accept;
      end
      default: push = 1'b0;
    endcase
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = q_pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_entry;
    end
  end

  assign q_valid_o = (count_q != 2'd0);
  assign q_entry_o = entry_q[rd_ptr_q];

endmodule

/* rtl/fegu_back.sv */
`timescale 1ns / 1ps
module fegu_back
  import fegu_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                 q_valid_i,
  input  q_entry_t             q_entry_i,
  output logic                 q_pop_o,
  output logic                 hold_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [OUT_IDX_W-1:0] cell_index_o,
  output logic [HEAT_W-1:0]    heat_o,
  output logic [COLOR_W-1:0]   color_o,
  output logic                 frame_done_o
);

  localparam int EW = CIDX_W + 6;

  back_state_e state_q, state_d;

  logic [HEAT_W-1:0] src_q, span_q;
  logic [WIND_W-1:0] wind_q;

  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [CIDX_W-1:0] cur_q, cur_d;
  logic [CIDX_W-1:0] ptr_q, ptr_d;
  logic [HEAT_W-1:0] fill_q, fill_d;
  logic              ign_out_q, ign_out_d;
  logic              init_q, init_d;

  logic [HEAT_W-1:0] decay_q, decay_d;
  logic [WIND_W-1:0] off_q, off_d;
  logic              neg_q, neg_d;
  logic [CIDX_W-1:0] rdidx_q, rdidx_d;

  logic                 out_valid_q, out_valid_d;
  logic [CIDX_W-1:0]    out_idx_q, out_idx_d;
  logic [HEAT_W-1:0]    out_heat_q, out_heat_d;
  logic                 out_done_q, out_done_d;
  logic                 load_out;
  logic                 out_free;

  logic                 ram_we, ram_re;
  logic [CIDX_W-1:0]    ram_waddr, ram_raddr;
  logic [HEAT_W-1:0]    ram_wdata, ram_rdata;

  logic [RAND_W+HEAT_W-1:0] decay_prod;
  logic [RAND_W+WIND_W-1:0] off_prod;
  logic [WIND_W-1:0]        wind_mag;
  logic                     wind_neg;
  logic [HEAT_W-1:0]        new_heat;
  logic [EW-1:0]            cur_e, off_e, sum_e;
  logic [CIDX_W-1:0]        widx;
  logic                     last_cell;
  logic [COL_W-1:0]         col_next;

  fegu_ram #(
    .WIDTH(HEAT_W),
    .DEPTH(CELL_COUNT)
  ) u_grid (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q  <= SOURCE_HEAT_RST;
      span_q <= DECAY_SPAN_RST;
      wind_q <= WIND_SHIFT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SOURCE_HEAT: src_q  <= cfg_data_i;
        CFG_DECAY_SPAN:  span_q <= cfg_data_i;
        CFG_WIND_SHIFT:  wind_q <= cfg_data_i[WIND_W-1:0];
        default: ;
      endcase
    end
  end

  // random scaling: the top bits of r*k are floor(r*k/2^32)
  always_comb begin
    wind_neg   = wind_q[WIND_W-1];
    wind_mag   = wind_neg ? (~wind_q + 1'b1) : wind_q;
    decay_prod = (RAND_W+HEAT_W)'(q_entry_i.rand_val) * (RAND_W+HEAT_W)'(span_q);
    off_prod   = (RAND_W+WIND_W)'(q_entry_i.rand_val) * (RAND_W+WIND_W)'(wind_mag);
  end

  // write address with wind offset, clamped to the grid
  always_comb begin
    new_heat = (ram_rdata > decay_q) ? (ram_rdata - decay_q) : '0;
    cur_e    = EW'(cur_q);
    off_e    = EW'(off_q);
    sum_e    = cur_e + off_e;
    if (neg_q) begin
      widx = (off_e > cur_e) ? '0 : CIDX_W'(cur_e - off_e);
    end else begin
      widx = (sum_e > EW'(LAST_CELL)) ? CIDX_W'(LAST_CELL) : CIDX_W'(sum_e);
    end
    last_cell = (row_q == ROW_W'(GRID_ROWS - 2)) && (col_q == COL_W'(GRID_COLS - 1));
    col_next  = (col_q == COL_W'(GRID_COLS - 1)) ? '0 : col_q + 1'b1;
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    col_d      = col_q;
    cur_d      = cur_q;
    ptr_d      = ptr_q;
    fill_d     = fill_q;
    ign_out_d  = ign_out_q;
    init_d     = init_q;
    decay_d    = decay_q;
    off_d      = off_q;
    neg_d      = neg_q;
    rdidx_d    = rdidx_q;
    q_pop_o    = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = ptr_q;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = cur_q + CIDX_W'(GRID_COLS);
    load_out   = 1'b0;
    out_idx_d  = out_idx_q;
    out_heat_d = out_heat_q;
    out_done_d = out_done_q;

    unique case (state_q)
      ST_CLEAR: begin
        // sweep: zero everything, bottom row gets the fill heat
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ram_wdata = (ptr_q >= CIDX_W'(BOTTOM_BASE)) ? fill_q : '0;
        if (ptr_q == CIDX_W'(LAST_CELL)) begin
          ptr_d   = '0;
          init_d  = 1'b0;
          state_d = ign_out_q ? ST_IGN_OUT : ST_IDLE;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          unique case (q_entry_i.op)
            OP_IGNITE: begin
              fill_d    = (src_q > HEAT_MAX) ? HEAT_MAX : src_q;
              ign_out_d = 1'b1;
              row_d     = '0;
              col_d     = '0;
              cur_d     = '0;
              ptr_d     = '0;
              state_d   = ST_CLEAR;
            end
            OP_PROPAGATE: begin
              ram_re    = 1'b1;
              ram_raddr = cur_q + CIDX_W'(GRID_COLS);
              decay_d   = decay_prod[RAND_W +: HEAT_W];
              off_d     = off_prod[RAND_W +: WIND_W];
              neg_d     = wind_neg;
              state_d   = ST_PROP;
            end
            OP_READ: begin
              ram_re    = 1'b1;
              ram_raddr = q_entry_i.rd_idx;
              rdidx_d   = q_entry_i.rd_idx;
              state_d   = ST_READ;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_PROP: begin
        if (out_free) begin
          ram_we     = 1'b1;
          ram_waddr  = widx;
          ram_wdata  = new_heat;
          load_out   = 1'b1;
          out_idx_d  = widx;
          out_heat_d = new_heat;
          out_done_d = last_cell;
          // column-major walk over all rows but the last
          if (row_q == ROW_W'(GRID_ROWS - 2)) begin
            row_d = '0;
            col_d = col_next;
            cur_d = CIDX_W'(col_next);
          end else begin
            row_d = row_q + 1'b1;
            cur_d = cur_q + CIDX_W'(GRID_COLS);
          end
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        if (out_free) begin
          load_out   = 1'b1;
          out_idx_d  = rdidx_q;
          out_heat_d = ram_rdata;
          out_done_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      ST_IGN_OUT: begin
        if (out_free) begin
          load_out   = 1'b1;
          out_idx_d  = CIDX_W'(BOTTOM_BASE);
          out_heat_d = fill_q;
          out_done_d = 1'b0;
          ign_out_d  = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      row_q       <= '0;
      col_q       <= '0;
      cur_q       <= '0;
      ptr_q       <= '0;
      fill_q      <= '0;
      ign_out_q   <= 1'b0;
      init_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      cur_q       <= cur_d;
      ptr_q       <= ptr_d;
      fill_q      <= fill_d;
      ign_out_q   <= ign_out_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    decay_q    <= decay_d;
    off_q      <= off_d;
    neg_q      <= neg_d;
    rdidx_q    <= rdidx_d;
    out_idx_q  <= out_idx_d;
    out_heat_q <= out_heat_d;
    out_done_q <= out_done_d;
  end

  assign hold_o       = init_q;
  assign out_valid_o  = out_valid_q;
  assign cell_index_o = OUT_IDX_W'(out_idx_q);
  assign heat_o       = out_heat_q;
  assign color_o      = heat_color(out_heat_q);
  assign frame_done_o = out_done_q;

endmodule

/* rtl/fire_effect_grid_update.sv */
`timescale 1ns / 1ps
// Fire-effect heat grid (40 x 40 cells of heat 0..36, one single-port-write RAM).
// Commands enter a two-entry queue, and the back end runs them one at a time.
// Propagate and read each run in the back end as the queue pop with the grid
// RAM read, then, once the output register is free, the write and the result.
// The back end takes the next command only after the result of the last one
// is loaded into the output register. Ignite pops the command, sweeps every
// grid cell through the RAM write port one per cycle, then gives its result.
// After reset a clearing pass with zero fill heat runs first, and no input
// beat is taken until it finishes. Configuration writes are accepted
// throughout. Command 3 is taken and dropped.
module fire_effect_grid_update
  import fegu_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            command_i,
  input  logic [RAND_W-1:0]     random_value_i,
  input  logic [5:0]            read_row_i,
  input  logic [5:0]            read_col_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [OUT_IDX_W-1:0]  cell_index_o,
  output logic [HEAT_W-1:0]     heat_o,
  output logic [COLOR_W-1:0]    color_o,
  output logic                  frame_done_o
);

  logic     q_valid;
  q_entry_t q_entry;
  logic     q_pop;
  logic     hold;

  fegu_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .random_value_i(random_value_i),
    .read_row_i    (read_row_i),
    .read_col_i    (read_col_i),
    .hold_i        (hold),
    .q_valid_o     (q_valid),
    .q_entry_o     (q_entry),
    .q_pop_i       (q_pop)
  );

  fegu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .q_pop_o     (q_pop),
    .hold_o      (hold),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cell_index_o(cell_index_o),
    .heat_o      (heat_o),
    .color_o     (color_o),
    .frame_done_o(frame_done_o)
  );

endmodule

/* dv/fire_effect_grid_update_tb.sv */
`timescale 1ns / 1ps

typedef struct packed {
  logic [10:0] idx;
  logic [5:0]  heat;
  logic [31:0] color;
  logic        done;
} cell_beat_t;

// mirror of the heat grid, cursor and registers; queues the cell beats it predicts
class heat_grid_mirror;
  logic [5:0]  cells [fegu_pkg::CELL_COUNT];
  logic [31:0] palette [37];
  int unsigned cur_row;
  int unsigned cur_col;
  logic [5:0]  source_heat;
  logic [5:0]  decay_span;
  logic [4:0]  wind_shift;
  cell_beat_t  pending_cells [$];
  int unsigned errors;
  int unsigned checked;
  int unsigned frames;
  int unsigned n_prop;
  int unsigned n_read;
  int unsigned n_ignite;
  int unsigned n_drop;

  function new();
    foreach (cells[i]) cells[i] = '0;
    cur_row = 0;
    cur_col = 0;
    source_heat = 6'd36;
    decay_span = 6'd3;
    wind_shift = 5'h1D;
    errors = 0;
    checked = 0;
    frames = 0;
    n_prop = 0;
    n_read = 0;
    n_ignite = 0;
    n_drop = 0;
    palette = '{
      32'hFF070707, 32'hFF1F0707, 32'hFF2F0F07, 32'hFF470F07, 32'hFF571707,
      32'hFF671F07, 32'hFF771F07, 32'hFF8F2707, 32'hFF9F2F07, 32'hFFAF3F07,
      32'hFFBF4707, 32'hFFC74707, 32'hFFDF4707, 32'hFFDF5707, 32'hFFDF5707,
      32'hFFD75F07, 32'hFFD75F07, 32'hFFD7670F, 32'hFFCF6F0F, 32'hFFCF770F,
      32'hFFCF7F0F, 32'hFFCF8717, 32'hFFC78717, 32'hFFC78F17, 32'hFFC7971F,
      32'hFFBF9F1F, 32'hFFBF9F1F, 32'hFFBFA727, 32'hFFBFA727, 32'hFFBFAF2F,
      32'hFFB7AF2F, 32'hFFB7B72F, 32'hFFB7B737, 32'hFFCFCF6F, 32'hFFDFDF9F,
      32'hFFEFEFC7, 32'hFFFFFFFF
    };
  endfunction

  function void write_reg(logic [1:0] index, logic [5:0] value);
    case (index)
      fegu_pkg::CFG_SOURCE_HEAT: source_heat = value;
      fegu_pkg::CFG_DECAY_SPAN:  decay_span = value;
      fegu_pkg::CFG_WIND_SHIFT:  wind_shift = value[4:0];
      default: ;
    endcase
  endfunction

  function void push_cell(int unsigned idx, int unsigned heat, logic done);
    cell_beat_t c;
    c.idx = idx[10:0];
    c.heat = heat[5:0];
    c.color = palette[heat > 36 ? 36 : heat];
    c.done = done;
    pending_cells.push_back(c);
  endfunction

  function void take_command(logic [1:0] cmd, logic [31:0] r, logic [5:0] row,
                             logic [5:0] col);
    logic [63:0] prod;
    int unsigned h;
    int unsigned decay;
    int unsigned mag;
    int unsigned off;
    int unsigned below;
    int unsigned rr;
    int unsigned cc;
    longint      pos;
    logic        neg;
    logic        done;
    case (cmd)
      fegu_pkg::CMD_IGNITE: begin
        n_ignite++;
        h = (source_heat > 6'd36) ? 36 : int'(source_heat);
        foreach (cells[i]) cells[i] = '0;
        for (int c = 0; c < fegu_pkg::GRID_COLS; c++) begin
          cells[fegu_pkg::BOTTOM_BASE + c] = h[5:0];
        end
        cur_row = 0;
        cur_col = 0;
        push_cell(fegu_pkg::BOTTOM_BASE, h, 1'b0);
      end
      fegu_pkg::CMD_PROPAGATE: begin
        n_prop++;
        prod = 64'(r) * 64'(decay_span);
        decay = prod[63:32];
        neg = wind_shift[4];
        mag = neg ? 32 - int'(wind_shift) : int'(wind_shift);
        prod = 64'(r) * 64'(mag);
        off = prod[63:32];
        below = cells[(cur_row + 1) * fegu_pkg::GRID_COLS + cur_col];
        h = (below > decay) ? below - decay : 0;
        pos = longint'(cur_row * fegu_pkg::GRID_COLS + cur_col);
        pos = neg ? pos - longint'(off) : pos + longint'(off);
        if (pos < 0) pos = 0;
        if (pos > fegu_pkg::LAST_CELL) pos = fegu_pkg::LAST_CELL;
        cells[int'(pos)] = h[5:0];
        done = (cur_row == fegu_pkg::GRID_ROWS - 2) && (cur_col == fegu_pkg::GRID_COLS - 1);
        if (done) frames++;
        cur_row++;
        if (cur_row >= fegu_pkg::GRID_ROWS - 1) begin
          cur_row = 0;
          cur_col++;
          if (cur_col >= fegu_pkg::GRID_COLS) cur_col = 0;
        end
        push_cell(int'(pos), h, done);
      end
      fegu_pkg::CMD_READ: begin
        n_read++;
        rr = (row > fegu_pkg::GRID_ROWS - 1) ? fegu_pkg::GRID_ROWS - 1 : int'(row);
        cc = (col > fegu_pkg::GRID_COLS - 1) ? fegu_pkg::GRID_COLS - 1 : int'(col);
        push_cell(rr * fegu_pkg::GRID_COLS + cc,
                  cells[rr * fegu_pkg::GRID_COLS + cc], 1'b0);
      end
      default: n_drop++;
    endcase
  endfunction

  function void check_cell(logic [10:0] idx, logic [5:0] heat, logic [31:0] color,
                           logic done);
    cell_beat_t e;
    if (pending_cells.size() == 0) begin
      $error("result beat with nothing pending: cell_index %0d heat %0d", idx, heat);
      errors++;
      return;
    end
    e = pending_cells.pop_front();
    checked++;
    if (idx !== e.idx) begin
      $error("cell_index: expected %0d, got %0d", e.idx, idx);
      errors++;
    end
    if (heat !== e.heat) begin
      $error("heat: expected %0d, got %0d", e.heat, heat);
      errors++;
    end
    if (color !== e.color) begin
      $error("color: expected %08h, got %08h", e.color, color);
      errors++;
    end
    if (done !== e.done) begin
      $error("frame_done: expected %0b, got %0b", e.done, done);
      errors++;
    end
  endfunction
endclass

module fire_effect_grid_update_tb;
  import fegu_pkg::*;

  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int DRAIN_CYCLES = 16;
  localparam int TAIL_CYCLES = 40;
  localparam int QUIET_LIMIT = 20000;
  // outlasts the ignite sweep so the output itself backs up
  localparam int HOLD_OFF_CYCLES = 2000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [1:0]            command_i;
  logic [RAND_W-1:0]     random_value_i;
  logic [5:0]            read_row_i;
  logic [5:0]            read_col_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [OUT_IDX_W-1:0]  cell_index_o;
  logic [HEAT_W-1:0]     heat_o;
  logic [COLOR_W-1:0]    color_o;
  logic                  frame_done_o;

  heat_grid_mirror mirror = new();

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_off_left;

  wire in_beat  = in_valid_i && !in_stall_o;
  wire out_beat = out_valid_o && !out_stall_i;

  fire_effect_grid_update i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .random_value_i (random_value_i),
    .read_row_i     (read_row_i),
    .read_col_i     (read_col_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cell_index_o   (cell_index_o),
    .heat_o         (heat_o),
    .color_o        (color_o),
    .frame_done_o   (frame_done_o)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // receiver: random stalls, or a long hold-off when one is requested
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_left > 0) begin
        out_stall_i <= 1'b1;
        hold_off_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // sampled mid-cycle, so the values are the ones seen at the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni && out_beat) begin
      mirror.check_cell(cell_index_o, heat_o, color_o, frame_done_o);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(negedge clk_i);
      if (!rst_ni || in_beat || out_beat) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_beat(input logic [1:0] cmd, input logic [31:0] r,
                           input logic [5:0] row, input logic [5:0] col);
    logic took;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    random_value_i <= r;
    read_row_i <= row;
    read_col_i <= col;
    do begin
      @(negedge clk_i);
      took = in_valid_i && !in_stall_o;
      @(posedge clk_i);
    end while (!took);
    mirror.take_command(cmd, r, row, col);
  endtask

  task automatic send_random_beat(input logic [1:0] cmd);
    send_beat(cmd, $urandom, 6'($urandom_range(63)), 6'($urandom_range(63)));
  endtask

  // block must be idle: every result in, plus room for a dropped command
  task automatic settle();
    in_valid_i <= 1'b0;
    while (mirror.pending_cells.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [5:0] src, input logic [5:0] span,
                            input logic [4:0] wind);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [5:0]           vals [3];
    idx = '{CFG_SOURCE_HEAT, CFG_DECAY_SPAN, CFG_WIND_SHIFT};
    vals = '{src, span, {1'b0, wind}};
    for (int k = 0; k < 3; k++) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i <= vals[k];
      @(posedge clk_i);
      mirror.write_reg(idx[k], vals[k]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_mix(input int unsigned count);
    int unsigned pick;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 3) send_random_beat(CMD_IGNITE);
      else if (pick < 6) send_random_beat(CMD_NOP);
      else if (pick < 20) send_random_beat(CMD_READ);
      else send_random_beat(CMD_PROPAGATE);
    end
  endtask

  initial begin
    int unsigned send_pcts [4];
    int unsigned stall_pcts [4];
    send_pcts = '{0, 64, 0, 37};
    stall_pcts = '{0, 0, 64, 37};
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_left = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    command_i = CMD_IGNITE;
    random_value_i = '0;
    read_row_i = '0;
    read_col_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // source heat above the cap, no decay, no wind; out-of-range reads saturate
    write_regs(6'd63, 6'd0, 5'd0);
    send_beat(CMD_IGNITE, 32'h0, 6'd0, 6'd0);
    send_beat(CMD_READ, 32'h0, 6'd63, 6'd63);
    send_beat(CMD_READ, 32'hFFFF_FFFF, 6'd39, 6'd0);
    send_beat(CMD_READ, 32'h0, 6'd0, 6'd63);
    send_beat(CMD_READ, 32'h0, 6'd40, 6'd39);
    send_beat(CMD_PROPAGATE, 32'h0, 6'd0, 6'd0);
    send_beat(CMD_PROPAGATE, 32'hFFFF_FFFF, 6'd63, 6'd63);
    send_random_beat(CMD_NOP);
    send_beat(CMD_READ, 32'h0, 6'd0, 6'd0);
    settle();

    // zero source, decay span past the heat range, strongest left wind clamps to 0
    write_regs(6'd0, 6'd63, 5'h10);
    send_beat(CMD_IGNITE, 32'hFFFF_FFFF, 6'd63, 6'd63);
    send_beat(CMD_PROPAGATE, 32'hFFFF_FFFF, 6'd0, 6'd0);
    send_beat(CMD_PROPAGATE, 32'h8000_0000, 6'd0, 6'd0);
    send_beat(CMD_READ, 32'h0, 6'd0, 6'd0);
    settle();

    // strongest right wind
    write_regs(6'd36, 6'd36, 5'h0F);
    send_beat(CMD_IGNITE, 32'h0, 6'd0, 6'd0);
    send_beat(CMD_PROPAGATE, 32'hFFFF_FFFF, 6'd0, 6'd0);
    send_beat(CMD_READ, 32'h0, 6'd0, 6'd14);
    send_beat(CMD_PROPAGATE, 32'h1234_5678, 6'd0, 6'd0);
    settle();

    write_regs(6'd20, 6'd1, 5'h18);
    send_beat(CMD_IGNITE, 32'h0, 6'd0, 6'd0);
    send_beat(CMD_READ, 32'h0, 6'd39, 6'd20);
    send_beat(CMD_PROPAGATE, 32'h7FFF_FFFF, 6'd0, 6'd0);
    send_beat(CMD_READ, 32'h0, 6'd1, 6'd0);
    settle();

    for (int p = 0; p < 4; p++) begin
      write_regs(6'($urandom_range(30, 63)), 6'($urandom_range(0, 4)),
                 5'($urandom_range(0, 31)));
      send_idle_pct = send_pcts[p];
      recv_stall_pct = stall_pcts[p];
      // receiver holds off while the sender keeps offering, so the input backs up
      if (p == 0) hold_off_left = HOLD_OFF_CYCLES;
      send_random_beat(CMD_IGNITE);
      run_mix(130);
      settle();
    end

    in_valid_i <= 1'b0;
    while (mirror.pending_cells.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d propagates, %0d reads, %0d ignites, %0d dropped commands",
             mirror.n_prop, mirror.n_read, mirror.n_ignite, mirror.n_drop);
    $display("%0d result beats checked, %0d frame ends, %0d mismatches",
             mirror.checked, mirror.frames, mirror.errors);
    if (mirror.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
